### rtl/core/haversine_footprint_check_assert.svh
// Assertion macros for the haversine footprint check.
`ifndef HAVERSINE_FOOTPRINT_CHECK_ASSERT_SVH
`define HAVERSINE_FOOTPRINT_CHECK_ASSERT_SVH

// same-cycle implication, disabled during reset
`define HFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hfc assertion failed");

// next-cycle implication, disabled during reset
`define HFC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hfc assertion failed");

`endif

### rtl/core/hfc_pkg.sv
// Package: constants, elaboration-time tables and types of the haversine footprint check.
package hfc_pkg;

	localparam int CORDIC_ITERATIONS = 32;
	localparam int ITER_W = $clog2(CORDIC_ITERATIONS);
	localparam int SQRT_STEPS = 61;
	localparam int SQRT_W = $clog2(SQRT_STEPS);

	typedef logic signed [63:0] q60_t;
	typedef q60_t atan_tab_t [CORDIC_ITERATIONS];

	localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;
	localparam logic [63:0] HALF_TURN_UNITS = 64'd1800000000;
	localparam logic [32:0] FULL_TURN_UNITS = 33'd3600000000;
	localparam q60_t ONE_Q60 = q60_t'(64'd1 << 60);
	localparam q60_t PI_Q60 = q60_t'((PI_Q62 + 64'd2) >> 2);
	localparam q60_t HALF_PI_Q60 = q60_t'((PI_Q62 + 64'd4) >> 3);
	localparam q60_t TWO_RADIUS_MM = q60_t'(64'd12742017600);
	localparam logic [63:0] DISTANCE_MAX = 64'd20015115071;
	localparam logic [34:0] RADIUS_RESET = 35'd1000000;

	localparam logic [63:0] RAD_Q1 = PI_Q62 / HALF_TURN_UNITS;
	localparam logic [63:0] RAD_R1 = PI_Q62 % HALF_TURN_UNITS;
	localparam logic [63:0] RAD_SCALE = (RAD_Q1 << 30) +
		((RAD_R1 << 30) + HALF_TURN_UNITS / 64'd2) / HALF_TURN_UNITS;

	// restoring division, elaboration only
	function automatic logic [63:0] cdiv(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], n[b]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// Q60 product, rounded half up on the magnitude
	function automatic q60_t cmulq(input q60_t a, input q60_t b);
		logic [63:0] ma;
		logic [63:0] mb;
		logic [127:0] p;
		logic [63:0] r;
		ma = a[63] ? 64'(-a) : 64'(a);
		mb = b[63] ? 64'(-b) : 64'(b);
		p = {64'd0, ma} * {64'd0, mb} + (128'd1 << 59);
		r = p[123:60];
		return (a[63] ^ b[63]) ? q60_t'(-r) : q60_t'(r);
	endfunction

	function automatic atan_tab_t build_atan();
		atan_tab_t t;
		q60_t sum;
		int e;
		logic [63:0] term;
		t[0] = q60_t'((PI_Q62 + 64'd8) >> 4);
		for (int i = 1; i < CORDIC_ITERATIONS; i++) begin
			sum = '0;
			for (int k = 0; k < 32; k++) begin
				e = 60 - i * (2 * k + 1);
				if (e >= 0) begin
					term = cdiv(64'd1 << e, 64'(2 * k + 1));
					sum = (k % 2 == 1) ? sum - q60_t'(term) : sum + q60_t'(term);
				end
			end
			t[i] = sum;
		end
		return t;
	endfunction

	// 1/G^2 by Newton iteration
	function automatic q60_t build_inv_gain_sq();
		logic [63:0] g;
		q60_t y;
		g = 64'd2 << 60;
		for (int i = 1; i < CORDIC_ITERATIONS; i++)
			if (2 * i < 63)
				g = g + (g >> (2 * i));
		y = (ONE_Q60 / 100) * 37;
		for (int i = 0; i < 8; i++)
			y = cmulq(y, (ONE_Q60 <<< 1) - cmulq(q60_t'(g), y));
		return y;
	endfunction

	localparam atan_tab_t ATAN_TAB = build_atan();
	localparam q60_t INV_GAIN_SQ = build_inv_gain_sq();

	typedef enum logic [1:0] {
		REG_ORIGIN_LAT = 2'd0,
		REG_ORIGIN_LON = 2'd1,
		REG_RADIUS     = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		SHR_32,
		SHR_33,
		SHR_60
	} mul_shift_t;

	typedef enum logic {
		CM_ROTATE,
		CM_VECTOR
	} cordic_mode_t;

	typedef enum logic [1:0] {
		TR_DLAT,
		TR_DLON,
		TR_OLAT,
		TR_LAT
	} trig_step_t;

	typedef enum logic [2:0] {
		PS_S1SQ,
		PS_S1G,
		PS_C1C2,
		PS_C1G,
		PS_S2SQ,
		PS_S2G,
		PS_FINAL
	} prod_step_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_ANG,
		ST_ANG_W,
		ST_ROT_W,
		ST_PROD,
		ST_PROD_W,
		ST_SUM,
		ST_SQRT_LD,
		ST_SQRT,
		ST_VEC,
		ST_VEC_W,
		ST_DIST,
		ST_DIST_W,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic       start;
		q60_t       a;
		q60_t       b;
		mul_shift_t shift;
	} mul_req_t;

	typedef struct packed {
		logic done;
		q60_t result;
	} mul_rsp_t;

	typedef struct packed {
		logic         start;
		cordic_mode_t mode;
		q60_t         x0;
		q60_t         y0;
		q60_t         z0;
	} cordic_req_t;

	typedef struct packed {
		logic done;
		q60_t x;
		q60_t y;
		q60_t z;
	} cordic_rsp_t;

endpackage

### rtl/core/hfc_point_if.sv
// Input channel: one geographic point per transfer.
interface hfc_point_if;
	logic               valid;
	logic               ready;
	logic signed [30:0] latitude;
	logic signed [31:0] longitude;

	modport source (output valid, latitude, longitude, input ready);
	modport sink (input valid, latitude, longitude, output ready);
endinterface

### rtl/core/hfc_result_if.sv
// Output channel: distance, footprint flag and running maximum.
interface hfc_result_if;
	logic        valid;
	logic        ready;
	logic [34:0] distance_mm;
	logic        beyond_footprint;
	logic [34:0] max_extent_mm;

	modport source (output valid, distance_mm, beyond_footprint, max_extent_mm, input ready);
	modport sink (input valid, distance_mm, beyond_footprint, max_extent_mm, output ready);
endinterface

### rtl/core/hfc_cfg_if.sv
// Configuration write channel.
interface hfc_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [34:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/hfc_mul.sv
// Sign-magnitude 64x64 multiply with rounded right shift on one 32x32 multiplier.
module hfc_mul (
	input  logic             clk,
	input  logic             arst_n,
	input  hfc_pkg::mul_req_t req,
	output hfc_pkg::mul_rsp_t rsp
);
	import hfc_pkg::*;

	localparam logic [2:0] PP_LAST = 3'd3;
	localparam logic [2:0] CNT_LAST = 3'd5;

	logic         busy_q;
	logic         done_q;
	logic [2:0]   cnt_q;
	logic [63:0]  am_q;
	logic [63:0]  bm_q;
	logic         neg_q;
	mul_shift_t   sh_q;
	logic [127:0] acc_q;
	logic [63:0]  pp_s1;
	logic [1:0]   off_s1;
	q60_t         res_q;

	logic [31:0]  a_half;
	logic [31:0]  b_half;
	logic [127:0] pp_ext;
	logic [127:0] rnd;
	logic [127:0] acc_sh;
	logic [63:0]  mag;

	assign a_half = cnt_q[1] ? am_q[63:32] : am_q[31:0];
	assign b_half = cnt_q[0] ? bm_q[63:32] : bm_q[31:0];

	always_comb begin
		case (off_s1)
			2'd0:    pp_ext = {64'd0, pp_s1};
			2'd1:    pp_ext = {32'd0, pp_s1, 32'd0};
			2'd2:    pp_ext = {pp_s1, 64'd0};
			default: pp_ext = '0;
		endcase
		case (req.shift)
			SHR_32:  rnd = 128'd1 << 31;
			SHR_33:  rnd = 128'd1 << 32;
			default: rnd = 128'd1 << 59;
		endcase
		case (sh_q)
			SHR_32:  acc_sh = acc_q >> 32;
			SHR_33:  acc_sh = acc_q >> 33;
			default: acc_sh = acc_q >> 60;
		endcase
		mag = acc_sh[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			am_q  <= req.a[63] ? 64'(-req.a) : 64'(req.a);
			bm_q  <= req.b[63] ? 64'(-req.b) : 64'(req.b);
			neg_q <= req.a[63] ^ req.b[63];
			sh_q  <= req.shift;
			acc_q <= rnd;
		end else if (busy_q) begin
			if (cnt_q <= PP_LAST) begin
				pp_s1  <= {32'd0, a_half} * {32'd0, b_half};
				off_s1 <= 2'({1'b0, cnt_q[1]} + {1'b0, cnt_q[0]});
			end
			if (cnt_q != 3'd0 && cnt_q <= PP_LAST + 3'd1)
				acc_q <= acc_q + pp_ext;
			if (cnt_q == CNT_LAST)
				res_q <= neg_q ? q60_t'(-mag) : q60_t'(mag);
		end
	end

	assign rsp.done = done_q;
	assign rsp.result = res_q;

endmodule

### rtl/core/hfc_cordic.sv
// CORDIC shift-add unit, one micro-rotation per cycle, rotation or vectoring.
module hfc_cordic (
	input  logic                clk,
	input  logic                arst_n,
	input  hfc_pkg::cordic_req_t req,
	output hfc_pkg::cordic_rsp_t rsp
);
	import hfc_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [ITER_W-1:0] cnt_q;
	cordic_mode_t      mode_q;
	q60_t              x_q;
	q60_t              y_q;
	q60_t              z_q;

	q60_t dx;
	q60_t dy;
	q60_t at;
	logic pos;

	always_comb begin
		dx  = y_q >>> cnt_q;
		dy  = x_q >>> cnt_q;
		at  = ATAN_TAB[cnt_q];
		// rotation drives z to zero, vectoring drives y to zero
		pos = (mode_q == CM_ROTATE) ? !z_q[63] : !(y_q > 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ITER_W'(CORDIC_ITERATIONS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			mode_q <= req.mode;
			x_q    <= req.x0;
			y_q    <= req.y0;
			z_q    <= req.z0;
		end else if (busy_q) begin
			if (pos) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.x = x_q;
	assign rsp.y = y_q;
	assign rsp.z = z_q;

endmodule

### rtl/core/haversine_footprint_check.sv
// Work: four 32-step CORDIC rotations, twelve multiplies on one 32x32 multiplier,
// two 61-step square roots and one CORDIC vectoring pass.
// A new point is taken only once the previous result sits in the output register;
// a stalled output register (result.ready low) holds back that load.
// Reset clears the sequencer, output valid, max extent and the origin registers,
// and sets the radius register to RADIUS_RESET.
module haversine_footprint_check (
	input logic          clk,
	input logic          arst_n,
	hfc_point_if.sink    point,
	hfc_result_if.source result,
	hfc_cfg_if.sink      cfg
);
	import hfc_pkg::*;
	`include "haversine_footprint_check_assert.svh"

	state_t state_q, state_d;

	logic signed [30:0] olat_q;
	logic signed [31:0] olon_q;
	logic [34:0]        radius_q;
	logic [34:0]        max_extent_q;

	logic signed [30:0] lat_q;
	logic signed [31:0] lon_q;
	logic [31:0]        mlat_q;
	logic [31:0]        mlon_q;
	trig_step_t         trig_q;
	prod_step_t         prod_q;
	logic               flip_q;
	q60_t               s1_q, s2_q, c1_q, c2_q;
	logic [60:0]        a_q;
	logic               pass_q;
	logic [SQRT_W-1:0]  sqrt_cnt_q;
	logic [121:0]       n_q;
	logic [65:0]        rem_q;
	logic [60:0]        root_q;
	logic [60:0]        xroot_q;
	q60_t               zang_q;
	logic [34:0]        dist_q;

	logic               res_valid_q;
	logic [34:0]        res_dist_q;
	logic               res_beyond_q;
	logic [34:0]        res_max_q;

	mul_req_t    mreq;
	mul_rsp_t    mrsp;
	cordic_req_t creq;
	cordic_rsp_t crsp;

	logic               in_xfer;
	logic               out_xfer;
	logic               load_out;
	logic signed [32:0] dlon;
	logic [32:0]        mlon_raw;
	logic signed [31:0] dlat;
	logic [31:0]        ang_op;
	q60_t               zin;
	logic               zflip;
	q60_t               a_sum;
	logic [60:0]        sqrt_val;
	logic [65:0]        rem_next;
	logic [65:0]        trial;
	q60_t               cos_val;

	hfc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	hfc_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (creq),
		.rsp    (crsp)
	);

	assign in_xfer = point.valid && point.ready;
	assign out_xfer = res_valid_q && result.ready;
	assign cfg.ready = 1'b1;

	// datapath helpers
	always_comb begin
		dlat = 32'(lat_q) - 32'(olat_q);
		dlon = 33'(lon_q) - 33'(olon_q);
		mlon_raw = dlon[32] ? 33'(-dlon) : 33'(dlon);

		case (trig_q)
			TR_DLAT: ang_op = mlat_q;
			TR_DLON: ang_op = mlon_q;
			TR_OLAT: ang_op = olat_q[30] ? 32'(-33'(olat_q)) : 32'(olat_q);
			default: ang_op = lat_q[30] ? 32'(-33'(lat_q)) : 32'(lat_q);
		endcase

		// fold the angle into [0, pi/2], remember a flipped cosine
		zin = mrsp.result;
		zflip = 1'b0;
		if (zin[63])
			zin = '0;
		else if (zin > PI_Q60)
			zin = PI_Q60;
		if (zin > HALF_PI_Q60) begin
			zin = PI_Q60 - zin;
			zflip = 1'b1;
		end
		cos_val = flip_q ? -crsp.x : crsp.x;

		a_sum = s1_q + c2_q;
		sqrt_val = pass_q ? a_q : 61'(ONE_Q60) - a_q;
		rem_next = {rem_q[63:0], n_q[121:120]};
		trial = {3'd0, root_q, 2'b01};
	end

	always_comb begin
		state_d = state_q;
		point.ready = 1'b0;
		load_out = 1'b0;
		mreq.start = 1'b0;
		mreq.a = {32'd0, ang_op};
		mreq.b = q60_t'(RAD_SCALE);
		mreq.shift = (trig_q == TR_DLAT || trig_q == TR_DLON) ? SHR_33 : SHR_32;
		creq.start = 1'b0;
		creq.mode = CM_ROTATE;
		creq.x0 = ONE_Q60;
		creq.y0 = '0;
		creq.z0 = zin;

		unique case (state_q)
			ST_IDLE: begin
				point.ready = 1'b1;
				if (in_xfer)
					state_d = ST_PREP;
			end
			ST_PREP: state_d = ST_ANG;
			ST_ANG: begin
				mreq.start = 1'b1;
				state_d = ST_ANG_W;
			end
			ST_ANG_W: begin
				if (mrsp.done) begin
					creq.start = 1'b1;
					state_d = ST_ROT_W;
				end
			end
			ST_ROT_W: begin
				if (crsp.done)
					state_d = (trig_q == TR_LAT) ? ST_PROD : ST_ANG;
			end
			ST_PROD: begin
				mreq.start = 1'b1;
				mreq.shift = SHR_60;
				case (prod_q)
					PS_S1SQ: begin mreq.a = s1_q; mreq.b = s1_q; end
					PS_S1G:  begin mreq.a = s1_q; mreq.b = INV_GAIN_SQ; end
					PS_C1C2: begin mreq.a = c1_q; mreq.b = c2_q; end
					PS_C1G:  begin mreq.a = c1_q; mreq.b = INV_GAIN_SQ; end
					PS_S2SQ: begin mreq.a = s2_q; mreq.b = s2_q; end
					PS_S2G:  begin mreq.a = s2_q; mreq.b = INV_GAIN_SQ; end
					default: begin mreq.a = c1_q; mreq.b = s2_q; end
				endcase
				state_d = ST_PROD_W;
			end
			ST_PROD_W: begin
				if (mrsp.done)
					state_d = (prod_q == PS_FINAL) ? ST_SUM : ST_PROD;
			end
			ST_SUM: state_d = ST_SQRT_LD;
			ST_SQRT_LD: state_d = ST_SQRT;
			ST_SQRT: begin
				if (sqrt_cnt_q == SQRT_W'(SQRT_STEPS - 1))
					state_d = pass_q ? ST_VEC : ST_SQRT_LD;
			end
			ST_VEC: begin
				creq.start = 1'b1;
				creq.mode = CM_VECTOR;
				creq.x0 = {3'd0, xroot_q};
				creq.y0 = {3'd0, root_q};
				creq.z0 = '0;
				state_d = ST_VEC_W;
			end
			ST_VEC_W: begin
				if (crsp.done)
					state_d = ST_DIST;
			end
			ST_DIST: begin
				mreq.start = 1'b1;
				mreq.a = zang_q;
				mreq.b = TWO_RADIUS_MM;
				mreq.shift = SHR_60;
				state_d = ST_DIST_W;
			end
			ST_DIST_W: begin
				if (mrsp.done)
					state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!res_valid_q || result.ready) begin
					load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// configuration registers, running maximum and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			olat_q       <= '0;
			olon_q       <= '0;
			radius_q     <= RADIUS_RESET;
			max_extent_q <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					REG_ORIGIN_LAT: olat_q <= cfg.data[30:0];
					REG_ORIGIN_LON: olon_q <= cfg.data[31:0];
					REG_RADIUS:     radius_q <= cfg.data;
					default: ;
				endcase
			end
			if (load_out) begin
				res_valid_q <= 1'b1;
				if (dist_q > max_extent_q)
					max_extent_q <= dist_q;
			end else if (out_xfer) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_q     <= TR_DLAT;
			prod_q     <= PS_S1SQ;
			pass_q     <= 1'b0;
			sqrt_cnt_q <= '0;
		end else begin
			if (state_q == ST_PREP)
				trig_q <= TR_DLAT;
			else if (state_q == ST_ROT_W && crsp.done)
				trig_q <= trig_step_t'(trig_q + 2'd1);
			if (state_q == ST_ROT_W)
				prod_q <= PS_S1SQ;
			else if (state_q == ST_PROD_W && mrsp.done)
				prod_q <= prod_step_t'(prod_q + 3'd1);
			if (state_q == ST_SUM)
				pass_q <= 1'b0;
			else if (state_q == ST_SQRT && sqrt_cnt_q == SQRT_W'(SQRT_STEPS - 1))
				pass_q <= 1'b1;
			if (state_q == ST_SQRT_LD)
				sqrt_cnt_q <= '0;
			else if (state_q == ST_SQRT)
				sqrt_cnt_q <= sqrt_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			lat_q <= point.latitude;
			lon_q <= point.longitude;
		end
		if (state_q == ST_PREP) begin
			mlat_q <= dlat[31] ? 32'(-33'(dlat)) : 32'(dlat);
			mlon_q <= (mlon_raw >= FULL_TURN_UNITS) ? 32'(mlon_raw - FULL_TURN_UNITS)
			                                        : 32'(mlon_raw);
		end
		if (state_q == ST_ANG_W && mrsp.done)
			flip_q <= zflip;
		if (state_q == ST_ROT_W && crsp.done) begin
			case (trig_q)
				TR_DLAT: s1_q <= crsp.y;
				TR_DLON: s2_q <= crsp.y;
				TR_OLAT: c1_q <= cos_val;
				default: c2_q <= cos_val;
			endcase
		end
		if (state_q == ST_PROD_W && mrsp.done) begin
			case (prod_q)
				PS_S1SQ, PS_S1G: s1_q <= mrsp.result;
				PS_C1C2, PS_C1G: c1_q <= mrsp.result;
				PS_S2SQ, PS_S2G: s2_q <= mrsp.result;
				default:         c2_q <= mrsp.result;
			endcase
		end
		if (state_q == ST_SUM) begin
			if (a_sum[63])
				a_q <= '0;
			else if (a_sum > ONE_Q60)
				a_q <= 61'(ONE_Q60);
			else
				a_q <= a_sum[60:0];
		end
		// digit-by-digit root of value * 2^60, two radicand bits per cycle
		if (state_q == ST_SQRT_LD) begin
			n_q    <= {1'b0, sqrt_val, 60'd0};
			rem_q  <= '0;
			root_q <= '0;
		end else if (state_q == ST_SQRT) begin
			n_q <= {n_q[119:0], 2'b00};
			if (rem_next >= trial) begin
				rem_q  <= rem_next - trial;
				root_q <= {root_q[59:0], 1'b1};
			end else begin
				rem_q  <= rem_next;
				root_q <= {root_q[59:0], 1'b0};
			end
			if (sqrt_cnt_q == SQRT_W'(SQRT_STEPS - 1) && !pass_q)
				xroot_q <= (rem_next >= trial) ? {root_q[59:0], 1'b1} : {root_q[59:0], 1'b0};
		end
		if (state_q == ST_VEC_W && crsp.done)
			zang_q <= crsp.z[63] ? '0 : crsp.z;
		if (state_q == ST_DIST_W && mrsp.done)
			dist_q <= (64'(mrsp.result) > DISTANCE_MAX) ? DISTANCE_MAX[34:0] : mrsp.result[34:0];
		if (load_out) begin
			res_dist_q   <= dist_q;
			res_beyond_q <= dist_q > radius_q;
			res_max_q    <= (dist_q > max_extent_q) ? dist_q : max_extent_q;
		end
	end

	assign result.valid = res_valid_q;
	assign result.distance_mm = res_dist_q;
	assign result.beyond_footprint = res_beyond_q;
	assign result.max_extent_mm = res_max_q;

	`HFC_ASSERT_NXT(a_max_mono, clk, arst_n, 1'b1, max_extent_q >= $past(max_extent_q))
	`HFC_ASSERT_IMP(a_max_covers, clk, arst_n, result.valid, result.max_extent_mm >= result.distance_mm)
	`HFC_ASSERT_IMP(a_dist_sat, clk, arst_n, result.valid, 64'(result.distance_mm) <= DISTANCE_MAX)
	`HFC_ASSERT_NXT(a_busy_after_take, clk, arst_n, point.valid && point.ready, !point.ready)

endmodule
